// File: rtl/sb64_pkg.sv
// Shared types, constants and the alphabet lookup for the strict base64 decoder.
package sb64_pkg;

  localparam logic [7:0] PadChar       = 8'h3D;  // '='
  localparam logic [6:0] NotSextet     = 7'd64;
  localparam logic [7:0] ExpectedReset = 8'd32;
  localparam int         FifoDepth     = 2;
  localparam int         FifoPtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int         FifoCntW      = $clog2(FifoDepth + 1);

  // One queue entry: what a single input item produces.
  typedef struct packed {
    logic [23:0] data;    // completed quad, first byte in the top bits
    logic [1:0]  nbytes;  // bytes to emit, 0..3
    logic        fin;     // end status follows the bytes
    logic        status;  // end status, 1 = bad
  } sb64_job_t;

  // Base64 alphabet lookup; NotSextet for anything outside it.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = NotSextet;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// File: rtl/sb64_front.sv
// Front end: accepts characters, tracks quad state and checks, builds queue entries.
module sb64_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  expected_bytes_we_i,
  input  logic [7:0]            expected_bytes_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_code_i,
  input  logic                  has_char_i,
  input  logic                  end_of_text_i,
  output logic                  push_o,
  output sb64_pkg::sb64_job_t   job_o,
  input  logic                  full_i
);

  logic [7:0]  exp_q;
  logic [1:0]  qpos_q, qpos_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  pad_q, pad_d;
  logic        pdone_q, pdone_d;
  logic [7:0]  bytes_q, bytes_d;
  logic        seen_q, seen_d;
  logic        err_q, err_d;

  logic        accept;
  logic [6:0]  sext;
  logic        is_sext;
  logic        is_pad;
  logic        quad_done;
  logic [1:0]  pad_new;
  logic [23:0] acc_new;
  logic [1:0]  nbytes;
  logic [1:0]  emit;
  logic [7:0]  room;
  logic        bad;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !full_i;
  assign sext       = sb64_pkg::sextet_of(char_code_i);
  assign is_sext    = !sext[6];
  assign is_pad     = (char_code_i == sb64_pkg::PadChar);

  always_comb begin
    qpos_d    = qpos_q;
    acc_d     = acc_q;
    pad_d     = pad_q;
    pdone_d   = pdone_q;
    bytes_d   = bytes_q;
    seen_d    = seen_q;
    err_d     = err_q;
    quad_done = 1'b0;
    pad_new   = pad_q;
    acc_new   = acc_q;
    nbytes    = 2'd0;
    emit      = 2'd0;
    room      = 8'd0;
    bad       = 1'b0;

    if (has_char_i) begin
      seen_d = 1'b1;
      if (!err_q) begin
        if (pdone_q) begin
          err_d = 1'b1;
        end else begin
          case (qpos_q)
            2'd0, 2'd1: begin
              if (!is_sext) begin
                err_d = 1'b1;
              end else begin
                acc_d  = {acc_q[17:0], sext[5:0]};
                qpos_d = qpos_q + 2'd1;
              end
            end
            2'd2: begin
              if (is_pad) begin
                if (acc_q[3:0] != 4'd0) begin
                  err_d = 1'b1;
                end else begin
                  pad_d  = pad_q | 2'b01;
                  acc_d  = {acc_q[17:0], 6'd0};
                  qpos_d = 2'd3;
                end
              end else if (!is_sext) begin
                err_d = 1'b1;
              end else begin
                acc_d  = {acc_q[17:0], sext[5:0]};
                qpos_d = 2'd3;
              end
            end
            default: begin
              if (is_pad) begin
                if (!pad_q[0] && acc_q[1:0] != 2'd0) begin
                  err_d = 1'b1;
                end else begin
                  quad_done = 1'b1;
                  pad_new   = pad_q | 2'b10;
                  acc_new   = {acc_q[17:0], 6'd0};
                end
              end else if (pad_q[0] || !is_sext) begin
                err_d = 1'b1;
              end else begin
                quad_done = 1'b1;
                acc_new   = {acc_q[17:0], sext[5:0]};
              end
            end
          endcase

          if (quad_done) begin
            nbytes = pad_new[0] ? 2'd1 : (pad_new[1] ? 2'd2 : 2'd3);
            // no room left once the count has reached the length
            room   = (bytes_q < exp_q) ? (exp_q - bytes_q) : 8'd0;
            if (room < {6'd0, nbytes}) begin
              emit  = room[1:0];
              err_d = 1'b1;
            end else begin
              emit  = nbytes;
            end
            bytes_d = bytes_q + {6'd0, emit};
            pdone_d = (pad_new != 2'b00);
            qpos_d  = 2'd0;
            pad_d   = 2'b00;
            acc_d   = 24'd0;
          end
        end
      end
    end

    if (end_of_text_i) begin
      bad     = err_d || !seen_d || (qpos_d != 2'd0) || (bytes_d != exp_q);
      qpos_d  = 2'd0;
      acc_d   = 24'd0;
      pad_d   = 2'b00;
      pdone_d = 1'b0;
      bytes_d = 8'd0;
      seen_d  = 1'b0;
      err_d   = 1'b0;
    end
  end

  assign job_o.data   = acc_new;
  assign job_o.nbytes = emit;
  assign job_o.fin    = end_of_text_i;
  assign job_o.status = bad;
  assign push_o       = accept && ((emit != 2'd0) || end_of_text_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= sb64_pkg::ExpectedReset;
      qpos_q  <= 2'd0;
      acc_q   <= 24'd0;
      pad_q   <= 2'b00;
      pdone_q <= 1'b0;
      bytes_q <= 8'd0;
      seen_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (expected_bytes_we_i) begin
        exp_q <= expected_bytes_i;
      end
      if (accept) begin
        qpos_q  <= qpos_d;
        acc_q   <= acc_d;
        pad_q   <= pad_d;
        pdone_q <= pdone_d;
        bytes_q <= bytes_d;
        seen_q  <= seen_d;
        err_q   <= err_d;
      end
    end
  end

  // A partial quad means a character was seen in this text.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (qpos_q != 2'd0) |-> seen_q)
    else $error("partial quad without any character");
  // Pad in the third place only exists at the fourth place.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pad_q[0] |-> (qpos_q == 2'd3))
    else $error("pad flag outside fourth place");
  // Nothing enters the queue without an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> accept)
    else $error("queue push without input beat");

endmodule

// File: rtl/sb64_fifo.sv
// Short queue of decode jobs between the front and back ends.
module sb64_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sb64_pkg::sb64_job_t   push_job_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output sb64_pkg::sb64_job_t   head_o
);

  sb64_pkg::sb64_job_t                mem_q [sb64_pkg::FifoDepth];
  logic [sb64_pkg::FifoPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [sb64_pkg::FifoCntW-1:0]      cnt_q;

  function automatic logic [sb64_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [sb64_pkg::FifoPtrW-1:0] p
  );
    logic [sb64_pkg::FifoPtrW-1:0] r;
    if (p == sb64_pkg::FifoPtrW'(sb64_pkg::FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == sb64_pkg::FifoCntW'(sb64_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q <= sb64_pkg::FifoCntW'(sb64_pkg::FifoDepth))
    else $error("queue count past depth");

endmodule

// File: rtl/sb64_back.sv
// Back end: unrolls each queue entry into result beats through an output register.
module sb64_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  sb64_pkg::sb64_job_t   head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  is_byte_o,
  output logic                  is_final_o,
  output logic                  status_o,
  output logic                  run_last_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       is_byte_q, is_final_q, status_q, run_last_q;

  logic       load;
  logic [2:0] total;
  logic       last;
  logic       take_byte;
  logic [7:0] sel_byte;

  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign total     = {1'b0, head_i.nbytes} + {2'd0, head_i.fin};
  assign last      = ({1'b0, idx_q} + 3'd1) == total;
  assign take_byte = idx_q < head_i.nbytes;
  assign pop_o     = load && last;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.data[23:16];
      2'd1:    sel_byte = head_i.data[15:8];
      default: sel_byte = head_i.data[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= take_byte ? sel_byte : 8'd0;
      is_byte_q  <= take_byte;
      is_final_q <= !take_byte;
      status_q   <= take_byte ? 1'b0 : head_i.status;
      run_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign is_byte_o   = is_byte_q;
  assign is_final_o  = is_final_q;
  assign status_o    = status_q;
  assign run_last_o  = run_last_q;

  // Every beat is exactly one of byte or final.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (is_byte_q ^ is_final_q))
    else $error("result beat kind is ambiguous");
  // The end status always closes the run of its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && is_final_q) |-> run_last_q)
    else $error("final beat not marked last");
  // A queue entry always produces at least one beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_valid_i |-> (total != 3'd0))
    else $error("empty job in queue");

endmodule

// File: rtl/strict_base64_decoder.sv
// Top level of the strict base64 decoder: front end, job queue and result back end.
//
// Takes base64 text one character per input beat (has_char_i = 0 with
// end_of_text_i sends a bare end marker) and returns one result beat per decoded
// byte, plus a final beat carrying status_o on the item flagged end_of_text_i
// (0 = well formed and exactly expected_bytes long). run_last_o marks the last
// beat an input caused; an input that neither completes a quad nor ends the text
// produces no beat. Input beats are checked and accepted at one per cycle in the
// front end as long as the two-entry job queue has room; the back end then
// drains each job through the output register at one result beat per cycle while
// the receiver is ready. An input that completes a quad yields up to three byte
// beats, plus the end status if it ends the text. On steady text the bytes of
// one quad drain while the next quad is gathered, so characters keep flowing at
// one per cycle; a bare end marker right behind a completed three-byte quad
// fills the queue and holds in_ready_o low until the back end takes that quad's
// last byte, and a stalling receiver backs the queue up the same way. Errors are
// sticky until the end of the text; bytes already sent are not withdrawn.
// expected_bytes is written through expected_bytes_we_i/expected_bytes_i,
// resets to 32, and may only change while the decoder is idle.
module strict_base64_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       expected_bytes_we_i,
  input  logic [7:0] expected_bytes_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       has_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_byte_o,
  output logic       is_final_o,
  output logic       status_o,
  output logic       run_last_o
);

  logic                push;
  sb64_pkg::sb64_job_t push_job;
  logic                full;
  logic                pop;
  logic                head_valid;
  sb64_pkg::sb64_job_t head;

  // Character checks and stream state; one beat per cycle while the queue has room.
  sb64_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .expected_bytes_we_i (expected_bytes_we_i),
    .expected_bytes_i    (expected_bytes_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .char_code_i         (char_code_i),
    .has_char_i          (has_char_i),
    .end_of_text_i       (end_of_text_i),
    .push_o              (push),
    .job_o               (push_job),
    .full_i              (full)
  );

  // Decouples the two sides so each can stall independently.
  sb64_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  // Serializes bytes and end status into result beats.
  sb64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .is_byte_o    (is_byte_o),
    .is_final_o   (is_final_o),
    .status_o     (status_o),
    .run_last_o   (run_last_o)
  );

endmodule

// File: dv/strict_base64_decoder_tb.sv
// Self-checking testbench for the strict base64 decoder: directed texts, then random traffic.
module strict_base64_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ASCII codes and alphabet offsets used by the decode model
  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [6:0] NO_SEXTET  = 7'd64;
  localparam logic [6:0] LOWER_BASE = 7'd26;
  localparam logic [6:0] DIGIT_BASE = 7'd52;
  localparam logic [6:0] PLUS_IDX   = 7'd62;
  localparam logic [6:0] SLASH_IDX  = 7'd63;
  localparam logic [7:0] RESET_LEN  = 8'd32;

  // Extra idle cycles after the last owed beat, to cover any quad still in flight.
  localparam int SETTLE_CYCLES = 8;

  typedef logic [7:0] char_q_t[$];

  // One output beat as the block presents it
  typedef struct packed {
    logic [7:0] data;
    logic       is_byte;
    logic       is_final;
    logic       status;
    logic       run_last;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       expected_bytes_we_i = 1'b0;
  logic [7:0] expected_bytes_i = 8'd0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = 8'd0;
  logic       has_char_i = 1'b0;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_byte_o;
  logic       is_final_o;
  logic       status_o;
  logic       run_last_o;

  strict_base64_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .expected_bytes_we_i(expected_bytes_we_i),
    .expected_bytes_i   (expected_bytes_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .char_code_i        (char_code_i),
    .has_char_i         (has_char_i),
    .end_of_text_i      (end_of_text_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .is_byte_o          (is_byte_o),
    .is_final_o         (is_final_o),
    .status_o           (status_o),
    .run_last_o         (run_last_o)
  );

  // Decoder model state: our own copy of what the block tracks per text
  logic [7:0]  expected_len = RESET_LEN;
  logic [1:0]  quad_pos     = 2'd0;
  logic [23:0] sextets      = 24'd0;   // pads shift in as zero
  logic [1:0]  pad_marks    = 2'd0;    // bit 0: third place pad, bit 1: fourth
  logic        padded_done  = 1'b0;    // a padded quad closed this text
  logic [7:0]  byte_count   = 8'd0;
  logic        saw_char     = 1'b0;
  logic        sticky_err   = 1'b0;

  beat_t decoded_beats[$];   // beats still owed by the block, oldest first
  beat_t head_beat;
  int    mismatches   = 0;
  int    beats_sent   = 0;   // char or end beats, fillers not counted
  int    tx_idle_pct  = 0;
  int    rx_stall_pct = 0;

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block wedges
  initial begin
    #2_000_000;
    $display("strict_base64_decoder_tb: errors");
    $finish;
  end

  // Receiver back-pressure, re-rolled every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Every accepted output beat is checked against the oldest owed beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_beats.size() == 0) begin
        report_mismatch("unexpected beat, byte", out_byte_o, 8'd0);
      end else begin
        head_beat = decoded_beats.pop_front();
        if (out_byte_o !== head_beat.data)
          report_mismatch("out_byte", out_byte_o, head_beat.data);
        if (is_byte_o !== head_beat.is_byte)
          report_mismatch("is_byte", 8'(is_byte_o), 8'(head_beat.is_byte));
        if (is_final_o !== head_beat.is_final)
          report_mismatch("is_final", 8'(is_final_o), 8'(head_beat.is_final));
        if (status_o !== head_beat.status)
          report_mismatch("status", 8'(status_o), 8'(head_beat.status));
        if (run_last_o !== head_beat.run_last)
          report_mismatch("run_last", 8'(run_last_o), 8'(head_beat.run_last));
      end
    end
  end

  // Alphabet lookup, NO_SEXTET for anything else ('=' included)
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - CH_LOWER_A) + LOWER_BASE;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return 7'(c - CH_DIGIT_0) + DIGIT_BASE;
    if (c == CH_PLUS) return PLUS_IDX;
    if (c == CH_SLASH) return SLASH_IDX;
    return NO_SEXTET;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < LOWER_BASE) return CH_UPPER_A + 8'(v);
    if (v < DIGIT_BASE) return CH_LOWER_A + 8'(v - LOWER_BASE);
    if (v < PLUS_IDX) return CH_DIGIT_0 + 8'(v - DIGIT_BASE);
    if (v == PLUS_IDX) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic char_q_t to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Advance the decode model by one accepted beat and queue the beats it owes.
  task automatic decode_beat(input logic [7:0] c, input logic has, input logic eot);
    beat_t      caused[$];
    beat_t      b;
    logic [6:0] v;
    logic       is_pad;
    int         n_out;
    int         k;
    v = sextet_value(c);
    is_pad = (c == PAD_CHAR);
    if (has) begin
      saw_char = 1'b1;
      if (!sticky_err) begin
        if (padded_done) begin
          // nothing may follow a padded quad
          sticky_err = 1'b1;
        end else if (quad_pos < 2'd2) begin
          if (v == NO_SEXTET) sticky_err = 1'b1;
          else begin
            sextets = {sextets[17:0], v[5:0]};
            quad_pos++;
          end
        end else if (quad_pos == 2'd2) begin
          // pad here needs the low four bits of the second sextet clear
          if (is_pad ? (sextets[3:0] != 4'd0) : (v == NO_SEXTET)) begin
            sticky_err = 1'b1;
          end else begin
            if (is_pad) pad_marks[0] = 1'b1;
            sextets = {sextets[17:0], is_pad ? 6'd0 : v[5:0]};
            quad_pos = 2'd3;
          end
        end else begin
          // fourth place: a third-place pad forces a pad; a lone fourth pad
          // needs the low two bits of the third sextet clear
          if (is_pad ? (!pad_marks[0] && sextets[1:0] != 2'd0)
                     : (pad_marks[0] || v == NO_SEXTET)) begin
            sticky_err = 1'b1;
          end else begin
            if (is_pad) pad_marks[1] = 1'b1;
            sextets = {sextets[17:0], is_pad ? 6'd0 : v[5:0]};
            n_out = pad_marks[0] ? 1 : (pad_marks[1] ? 2 : 3);
            padded_done = (pad_marks != 2'd0);
            k = 0;
            // bytes stop at the first one past the expected length
            while (k < n_out && !sticky_err) begin
              if (byte_count >= expected_len) begin
                sticky_err = 1'b1;
              end else begin
                b = '0;
                b.data = sextets[23 - 8 * k -: 8];
                b.is_byte = 1'b1;
                caused.push_back(b);
                byte_count++;
              end
              k++;
            end
            quad_pos = 2'd0;
            pad_marks = 2'd0;
            sextets = 24'd0;
          end
        end
      end
    end
    if (eot) begin
      b = '0;
      b.is_final = 1'b1;
      b.status = sticky_err || !saw_char || quad_pos != 2'd0 || byte_count != expected_len;
      caused.push_back(b);
      quad_pos = 2'd0;
      sextets = 24'd0;
      pad_marks = 2'd0;
      padded_done = 1'b0;
      byte_count = 8'd0;
      saw_char = 1'b0;
      sticky_err = 1'b0;
    end
    if (caused.size() > 0) caused[caused.size() - 1].run_last = 1'b1;
    foreach (caused[i]) decoded_beats.push_back(caused[i]);
  endtask

  // Send one input beat; valid stays up across back-to-back beats.
  task automatic send_beat(input logic [7:0] c, input logic has, input logic eot);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    has_char_i    <= has;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    if (has || eot) beats_sent++;
    decode_beat(c, has, eot);
  endtask

  // One text: end flag on the last char, or a bare end marker after it.
  // Fillers (no char, no end) are sprinkled in at filler_pct.
  task automatic send_text(input char_q_t chars, input bit bare_end, input int filler_pct);
    for (int i = 0; i < chars.size(); i++) begin
      if ($urandom_range(0, 99) < filler_pct) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(chars[i], 1'b1, !bare_end && i == chars.size() - 1);
    end
    if (bare_end) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Drop valid and wait until the block owes nothing and has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (decoded_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_expected(input logic [7:0] len);
    settle();
    expected_bytes_we_i <= 1'b1;
    expected_bytes_i    <= len;
    @(posedge clk_i);
    expected_bytes_we_i <= 1'b0;
    expected_len = len;
  endtask

  // Runs at the reset value of the length register: a partial text ended by a bare marker.
  task automatic test_reset_length();
    send_text(to_chars("TW"), 1'b1, 0);
  endtask

  // Clean texts: full quad ending on a char, one-pad quad.
  task automatic test_well_formed();
    set_expected(8'd3);
    send_text(to_chars("TWFu"), 1'b0, 0);
    set_expected(8'd2);
    send_text(to_chars("TWE="), 1'b0, 0);
  endtask

  // Pad rules: dirty bits under a fourth-place pad, a third-place pad
  // followed by a letter, a char after a padded quad.
  task automatic test_pad_rules();
    send_text(to_chars("TWF="), 1'b0, 0);
    send_text(to_chars("TQ=u"), 1'b0, 0);
    set_expected(8'd1);
    send_text(to_chars("TQ==A"), 1'b0, 0);
  endtask

  // Pad in the first place, code extremes after the error, then an empty text.
  task automatic test_bad_chars();
    send_beat(PAD_CHAR, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(CH_DASH, 1'b0, 1'b1);
  endtask

  // A quad running past the length, and a zero length that fails everything.
  task automatic test_length_limits();
    send_text(to_chars("TWFu"), 1'b0, 0);
    set_expected(8'd0);
    send_text(to_chars("TQ=="), 1'b0, 0);
  endtask

  // Mostly well-formed texts with random bytes, some of them damaged.
  task automatic random_text();
    logic [7:0]  raw[$];
    char_q_t     txt;
    logic [23:0] grp;
    int          nb;
    int          r;
    nb = ($urandom_range(0, 99) < 65 && expected_len != 0 && expected_len <= 12) ?
         int'(expected_len) : $urandom_range(1, 7);
    for (int i = 0; i < nb + 2; i++) raw.push_back(i < nb ? 8'($urandom_range(0, 255)) : 8'd0);
    for (int i = 0; i < nb; i += 3) begin
      grp = {raw[i], raw[i + 1], raw[i + 2]};
      txt.push_back(alphabet_char(grp[23:18]));
      txt.push_back(alphabet_char(grp[17:12]));
      txt.push_back(nb - i > 1 ? alphabet_char(grp[11:6]) : PAD_CHAR);
      txt.push_back(nb - i > 2 ? alphabet_char(grp[5:0]) : PAD_CHAR);
    end
    r = $urandom_range(0, 99);
    if (r < 14) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    else if (r < 22) txt[$urandom_range(0, txt.size() - 1)] = PAD_CHAR;
    else if (r < 29) void'(txt.pop_back());                  // partial quad left over
    else if (r < 36) txt.push_back(alphabet_char(6'($urandom_range(0, 63))));
    else if (r < 44) txt[txt.size() - 2] = alphabet_char(6'($urandom_range(0, 63)));
    else if (r < 48) txt.delete();                           // empty text
    send_text(txt, txt.size() == 0 || $urandom_range(0, 1) == 1, 6);
  endtask

  task automatic random_phase(input int n_beats, input logic [7:0] len,
                              input int tx_pct, input int rx_pct);
    int start;
    set_expected(len);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start = beats_sent;
    while (beats_sent - start < n_beats) random_text();
  endtask

  // Random traffic across lengths from 1 up to 255, and idle mixes.
  task automatic test_random_traffic();
    random_phase(12, 8'd3, 0, 0);
    random_phase(10, 8'd1, 66, 0);
    random_phase(12, 8'd6, 0, 66);
    random_phase(10, 8'd4, 22, 22);
    random_phase(6, 8'd255, 22, 22);
    settle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_length();
    test_well_formed();
    test_pad_rules();
    test_bad_chars();
    test_length_limits();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("strict_base64_decoder_tb: clean");
    end else begin
      $display("strict_base64_decoder_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sb64_pkg.sv
rtl/sb64_front.sv
rtl/sb64_fifo.sv
rtl/sb64_back.sv
rtl/strict_base64_decoder.sv
dv/strict_base64_decoder_tb.sv
